/* design/bucket_priority_queue_defines.svh */
// ----------------------------------------------------------------------------
// bucket priority queue assertion macros
// shared assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BUCKET_PRIORITY_QUEUE_DEFINES_SVH
`define BUCKET_PRIORITY_QUEUE_DEFINES_SVH

// invariant that holds at every edge out of reset
`define BPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition implies consequence in the same cycle
`define BPQ_ASSERT_IMP(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

`endif

/* design/bpq_pkg.sv */
// ----------------------------------------------------------------------------
// bpq package
// status codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package bpq_pkg;

  localparam logic       OP_ENQ      = 1'b0;
  localparam logic       OP_DEQ      = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_PRIO = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [3:0] MAX_PRIO_RESET = 4'd15;

  typedef struct packed {
    logic latch;
    logic decide;
    logic en_rd;
    logic en_wr;
    logic en_link;
    logic dq_rd;
    logic dq_link;
    logic dq_wr;
    logic out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic fail;
    logic is_deq;
    logic link_needed;
  } dp_stat_t;

endpackage

/* design/bpq_ram.sv */
// ----------------------------------------------------------------------------
// bpq generic ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module bpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/bpq_ctrl.sv */
// ----------------------------------------------------------------------------
// bpq controller
// sequences enqueue, dequeue and head lookup steps of the datapath
// ----------------------------------------------------------------------------
module bpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  bpq_pkg::dp_stat_t  stat,
  output bpq_pkg::dp_cmd_t   cmd,
  output logic               busy
);

  import bpq_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_DECIDE  = 11'b00000000010,
    S_EN_RD   = 11'b00000000100,
    S_EN_WR   = 11'b00000001000,
    S_EN_LINK = 11'b00000010000,
    S_DQ_RD   = 11'b00000100000,
    S_DQ_LINK = 11'b00001000000,
    S_DQ_WR   = 11'b00010000000,
    S_HD_LV   = 11'b00100000000,
    S_HD_VAL  = 11'b01000000000,
    S_OUT     = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.fail) state_next = S_HD_LV;
        else if (stat.is_deq) state_next = S_DQ_RD;
        else state_next = S_EN_RD;
      end
      S_EN_RD:   state_next = S_EN_WR;
      S_EN_WR:   state_next = stat.link_needed ? S_EN_LINK : S_HD_LV;
      S_EN_LINK: state_next = S_HD_LV;
      S_DQ_RD:   state_next = S_DQ_LINK;
      S_DQ_LINK: state_next = S_DQ_WR;
      S_DQ_WR:   state_next = S_HD_LV;
      S_HD_LV:   state_next = S_HD_VAL;
      S_HD_VAL:  state_next = S_OUT;
      S_OUT:     state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  assign busy        = (state != S_IDLE);
  assign cmd.latch   = (state == S_IDLE) && start;
  assign cmd.decide  = (state == S_DECIDE);
  assign cmd.en_rd   = (state == S_EN_RD);
  assign cmd.en_wr   = (state == S_EN_WR);
  assign cmd.en_link = (state == S_EN_LINK);
  assign cmd.dq_rd   = (state == S_DQ_RD);
  assign cmd.dq_link = (state == S_DQ_LINK);
  assign cmd.dq_wr   = (state == S_DQ_WR);
  assign cmd.out_ld  = (state == S_OUT);

endmodule

/* design/bpq_dpath.sv */
// ----------------------------------------------------------------------------
// bpq datapath
// linked-list stores, free list, level flags and result registers
// ----------------------------------------------------------------------------
`include "bucket_priority_queue_defines.svh"

module bpq_dpath #(
  parameter int LEVELS     = 16,
  parameter int CAPACITY   = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  bpq_pkg::dp_cmd_t  cmd,
  output bpq_pkg::dp_stat_t stat,
  input  logic              op,
  input  logic [31:0]       elem_value,
  input  logic [7:0]        prio_level,
  input  logic              cfg_valid,
  input  logic [3:0]        cfg_data,
  output logic              done,
  output logic [1:0]        status,
  output logic [31:0]       head_value,
  output logic [3:0]        head_level,
  output logic [6:0]        entry_count,
  output logic              is_empty
);

  import bpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(LEVELS);
  localparam int CW = $clog2(CAPACITY + 1);

  function automatic logic [LW-1:0] lowest_lvl(input logic [LEVELS-1:0] v);
    logic [LW-1:0] r;
    r = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (v[i]) r = LW'(i);
    end
    return r;
  endfunction

  logic                  op_r;
  logic [ELEM_WIDTH-1:0] val_r;
  logic [7:0]            prio_r;
  logic [3:0]            max_prio;
  logic [AW-1:0]         free_head;
  logic [CW-1:0]         count;
  logic [CW-1:0]         fresh;
  logic [LEVELS-1:0]     nonempty;
  logic [AW-1:0]         slot_r;
  logic [AW-1:0]         tail_old;
  logic [LW-1:0]         lv_r;
  logic                  same_r;

  logic [63:0]           in_wide;
  logic [63:0]           val_wide;
  logic [LW-1:0]         p;
  logic [LW-1:0]         low;
  logic [1:0]            stat_calc;
  logic                  slot_fresh;
  logic [AW-1:0]         slot_succ;

  logic                  link_we;
  logic [AW-1:0]         link_wa, link_wd, link_ra, link_rd;
  logic                  head_we;
  logic [LW-1:0]         head_wa;
  logic [AW-1:0]         head_wd, head_rd;
  logic [LW-1:0]         tail_ra;
  logic [AW-1:0]         tail_rd;
  logic [ELEM_WIDTH-1:0] val_rd;

  assign in_wide    = 64'(elem_value);
  assign val_wide   = 64'(val_rd);
  assign p          = prio_r[LW-1:0];
  assign low        = lowest_lvl(nonempty);
  assign slot_fresh = ({1'b0, slot_r} >= {1'b0, fresh});
  assign slot_succ  = (slot_r == AW'(CAPACITY - 1)) ? '0 : slot_r + 1'b1;

  always_comb begin
    stat_calc = ST_OK;
    if (op_r == OP_ENQ) begin
      if ((prio_r > {4'd0, max_prio}) || ({1'b0, prio_r} >= 9'(LEVELS))) begin
        stat_calc = ST_BAD_PRIO;
      end else if (count >= CW'(CAPACITY)) begin
        stat_calc = ST_FULL;
      end
    end else if (nonempty == '0) begin
      stat_calc = ST_EMPTY;
    end
  end

  assign stat.fail        = (stat_calc != ST_OK);
  assign stat.is_deq      = (op_r == OP_DEQ);
  assign stat.link_needed = nonempty[p];

  // link store
  assign link_ra = cmd.en_rd ? free_head : head_rd;
  assign link_we = cmd.en_wr | cmd.en_link | cmd.dq_wr;
  assign link_wa = cmd.en_link ? tail_old : slot_r;
  assign link_wd = cmd.dq_wr ? free_head : slot_r;

  // level heads and tails
  assign head_we = (cmd.en_wr && !nonempty[p]) || (cmd.dq_wr && !same_r);
  assign head_wa = cmd.en_wr ? p : lv_r;
  assign head_wd = cmd.en_wr ? slot_r : link_rd;
  assign tail_ra = cmd.en_rd ? p : low;

  bpq_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
    .clk(clk), .wr_en(cmd.en_rd), .wr_addr(free_head), .wr_data(val_r),
    .rd_addr(head_rd), .rd_data(val_rd)
  );

  bpq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link_ram (
    .clk(clk), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
    .rd_addr(link_ra), .rd_data(link_rd)
  );

  bpq_ram #(.WIDTH(AW), .DEPTH(LEVELS)) u_head_ram (
    .clk(clk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
    .rd_addr(low), .rd_data(head_rd)
  );

  bpq_ram #(.WIDTH(AW), .DEPTH(LEVELS)) u_tail_ram (
    .clk(clk), .wr_en(cmd.en_wr), .wr_addr(p), .wr_data(slot_r),
    .rd_addr(tail_ra), .rd_data(tail_rd)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= op;
      val_r  <= in_wide[ELEM_WIDTH-1:0];
      prio_r <= prio_level;
    end
    if (cmd.decide) status <= stat_calc;
    if (cmd.en_rd) slot_r <= free_head;
    if (cmd.dq_link) begin
      slot_r <= head_rd;
      same_r <= (head_rd == tail_rd);
    end
    if (cmd.en_wr) tail_old <= tail_rd;
    if (cmd.dq_rd) lv_r <= low;
    if (cmd.out_ld) begin
      head_value  <= (nonempty != '0) ? val_wide[31:0] : 32'd0;
      head_level  <= (nonempty != '0) ? 4'(low) : 4'd0;
      entry_count <= 7'(count);
      is_empty    <= (count == '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_prio  <= MAX_PRIO_RESET;
      free_head <= '0;
      count     <= '0;
      fresh     <= '0;
      nonempty  <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.out_ld;
      if (cfg_valid) max_prio <= cfg_data;
      if (cmd.en_wr) begin
        // slots never handed out still follow the reset chain
        free_head   <= slot_fresh ? slot_succ : link_rd;
        if (slot_fresh) fresh <= fresh + 1'b1;
        nonempty[p] <= 1'b1;
        count       <= count + 1'b1;
      end
      if (cmd.dq_wr) begin
        free_head <= slot_r;
        count     <= count - 1'b1;
        if (same_r) nonempty[lv_r] <= 1'b0;
      end
    end
  end

  `BPQ_ASSERT(a_count_cap, count <= CW'(CAPACITY), "entry count above capacity")
  `BPQ_ASSERT(a_count_flags, (count == '0) == (nonempty == '0), "count and level flags disagree")
  `BPQ_ASSERT(a_fresh_count, fresh >= count, "more entries than slots ever allocated")
  `BPQ_ASSERT_IMP(a_deq_nonempty, cmd.dq_rd, nonempty != '0, "dequeue walk on empty queue")

endmodule

/* design/bucket_priority_queue.sv */
// ----------------------------------------------------------------------------
// bucket priority queue
// one fifo per priority level over a shared pool of linked slots
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command gives
// one result, shown for a single cycle with done high; the receiver cannot
// stall it. A rejected command skips to the head lookup; an enqueue adds a
// link step when its level already holds elements. Each step waits on one
// registered read of the slot, link or level memories, and the head lookup
// after every command reads the level head, then its value. busy falls in the
// cycle done is high, so the next command may be issued then. The priority
// limit must be written through cfg_valid/cfg_ready while idle, unenforced.
module bucket_priority_queue #(
  parameter int LEVELS     = 16,
  parameter int CAPACITY   = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [31:0] elem_value,
  input  logic [7:0]  prio_level,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] head_value,
  output logic [3:0]  head_level,
  output logic [6:0]  entry_count,
  output logic        is_empty
);

  import bpq_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  assign cfg_ready = 1'b1;

  bpq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(dstat), .cmd(dcmd), .busy(busy)
  );

  bpq_dpath #(.LEVELS(LEVELS), .CAPACITY(CAPACITY), .ELEM_WIDTH(ELEM_WIDTH)) u_dpath (
    .clk(clk), .rst(rst), .cmd(dcmd), .stat(dstat),
    .op(cmd), .elem_value(elem_value), .prio_level(prio_level),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .done(done), .status(status), .head_value(head_value),
    .head_level(head_level), .entry_count(entry_count), .is_empty(is_empty)
  );

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// bucket priority queue testbench
// drives enqueue and dequeue commands and priority limit writes, predicts every
// result with a per-level fifo model and checks each field as it appears
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bpq_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] head_value;
    logic [3:0]  head_level;
    logic [6:0]  entry_count;
    logic        is_empty;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cmd;
  logic [31:0] elem_value;
  logic [7:0]  prio_level;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;
  logic        done;
  logic [1:0]  status;
  logic [31:0] head_value;
  logic [3:0]  head_level;
  logic [6:0]  entry_count;
  logic        is_empty;

  bucket_priority_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .elem_value(elem_value), .prio_level(prio_level), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done), .status(status),
    .head_value(head_value), .head_level(head_level), .entry_count(entry_count),
    .is_empty(is_empty)
  );

  localparam int NUM_LEVELS = 16;
  localparam int POOL_SIZE = 64;

  // per-level fifos of stored elements
  logic [31:0] level_fifo[NUM_LEVELS][$];
  logic [3:0]  prio_limit;
  int          stored;
  outcome_t    expected_q[$];
  int          errors;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic outcome_t predict_queue(input logic op, input logic [31:0] val,
                                             input logic [7:0] lvl);
    outcome_t r;
    int found;
    r = '0;
    r.status = ST_OK;
    if (op == OP_ENQ) begin
      if (lvl > prio_limit || lvl >= NUM_LEVELS) r.status = ST_BAD_PRIO;
      else if (stored >= POOL_SIZE) r.status = ST_FULL;
      else begin
        level_fifo[lvl].push_back(val);
        stored++;
      end
    end else begin
      if (stored == 0) r.status = ST_EMPTY;
      else begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          if (level_fifo[i].size() > 0) begin
            void'(level_fifo[i].pop_front());
            break;
          end
        end
        stored--;
      end
    end
    found = 0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (!found && level_fifo[i].size() > 0) begin
        r.head_value = level_fifo[i][0];
        r.head_level = 4'(i);
        found = 1;
      end
    end
    r.entry_count = 7'(stored);
    r.is_empty = (stored == 0);
    return r;
  endfunction

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 40) n = 0;
    else if (n < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_command(input logic op, input logic [31:0] val,
                              input logic [7:0] lvl, input bit gaps);
    if (gaps) idle_gap();
    start <= 1'b1;
    cmd <= op;
    elem_value <= val;
    prio_level <= lvl;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_queue(op, val, lvl));
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_q.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_limit(input logic [3:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    prio_limit = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    outcome_t w;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", 32'd1, 32'd0);
      end else begin
        w = expected_q.pop_front();
        if (status !== w.status) report("status", 32'(status), 32'(w.status));
        if (head_value !== w.head_value) report("head_value", head_value, w.head_value);
        if (head_level !== w.head_level)
          report("head_level", 32'(head_level), 32'(w.head_level));
        if (entry_count !== w.entry_count)
          report("entry_count", 32'(entry_count), 32'(w.entry_count));
        if (is_empty !== w.is_empty) report("is_empty", 32'(is_empty), 32'(w.is_empty));
      end
    end
  end

  task automatic test_directed();
    send_command(OP_DEQ, 32'h0, 8'd0, 1'b0);
    send_command(OP_ENQ, 32'hFFFF_FFFF, 8'd15, 1'b0);
    send_command(OP_ENQ, 32'h0, 8'd0, 1'b0);
    send_command(OP_ENQ, 32'hA5A5_5A5A, 8'd0, 1'b0);
    send_command(OP_ENQ, 32'h1234_5678, 8'd16, 1'b0);
    send_command(OP_ENQ, 32'h1, 8'd255, 1'b0);
    send_command(OP_ENQ, 32'h8000_0000, 8'd7, 1'b0);
    repeat (5) send_command(OP_DEQ, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    write_limit(4'd0);
    send_command(OP_ENQ, 32'h55, 8'd1, 1'b0);
    send_command(OP_ENQ, 32'h66, 8'd0, 1'b0);
    write_limit(4'd15);
  endtask

  task automatic test_full();
    for (int i = 0; i < POOL_SIZE + 3; i++)
      send_command(OP_ENQ, $urandom, 8'($urandom_range(0, 15)), 1'b1);
    write_limit(4'd3);
    send_command(OP_ENQ, $urandom, 8'd9, 1'b0);
    for (int i = 0; i < POOL_SIZE + 2; i++)
      send_command(OP_DEQ, $urandom, 8'($urandom), 1'b1);
  endtask

  task automatic test_random();
    logic [7:0] lvl;
    int sel;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) write_limit(4'd15);
      else if (phase == 5) write_limit(4'd0);
      else write_limit(4'($urandom));
      for (int i = 0; i < 150; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 10) lvl = 8'($urandom);
        else lvl = 8'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < (phase[0] ? 40 : 62))
          send_command(OP_ENQ, $urandom, lvl, 1'b1);
        else
          send_command(OP_DEQ, $urandom, 8'($urandom), 1'b1);
      end
    end
    write_limit(4'd15);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = OP_ENQ;
    elem_value = '0;
    prio_level = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    stored = 0;
    prio_limit = MAX_PRIO_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full();
    test_random();
    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule
